// ===== src/dose_set_statistics_macros.svh =====
// Assertion helpers for the dose set statistics block.
// Both macros expect clk_i and rst_ni in the scope where they are used.
`ifndef DOSE_SET_STATISTICS_MACROS_SVH
`define DOSE_SET_STATISTICS_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define DSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/dss_pkg.sv =====
// ----------------------------------------------------------------------------
// dss_pkg
// Shared widths, payload structs, controller states and commands for the
// dose set statistics block.
// ----------------------------------------------------------------------------
package dss_pkg;

  localparam int DOSE_W          = 16;
  localparam int COUNT_OUT_W     = 17;
  localparam int MAX_SAMPLES_DEF = 65536;
  localparam int RAD_W           = 2 * DOSE_W;
  localparam int ROOT_STEPS      = RAD_W / 2;

  typedef struct packed {
    logic [DOSE_W-1:0] dose_sample;
    logic              last_sample;
  } dss_in_t;

  typedef struct packed {
    logic [DOSE_W-1:0]      min_dose;
    logic [DOSE_W-1:0]      max_dose;
    logic [DOSE_W-1:0]      mean_dose;
    logic [DOSE_W-1:0]      rms_deviation;
    logic [COUNT_OUT_W-1:0] sample_count;
  } dss_out_t;

  typedef enum logic [2:0] {
    S_ACCUM,
    S_MEAN_LD,
    S_MEAN_RUN,
    S_SQ_LD,
    S_SQ_RUN,
    S_ROOT_LD,
    S_ROOT_RUN,
    S_DONE
  } dss_state_e;

  typedef struct packed {
    logic accept;     // take one sample into the accumulators
    logic mean_load;  // load the divider with the sum
    logic sq_load;    // keep the mean, load the divider with the squared sum
    logic div_step;   // one quotient bit
    logic root_load;  // load the root unit with the squared quotient
    logic root_step;  // one root bit
    logic out_load;   // fill the output register, clear the accumulators
  } dss_cmd_t;

endpackage

// ===== src/dose_set_statistics.sv =====
// ----------------------------------------------------------------------------
// dose_set_statistics
// Min, max, mean and RMS deviation from a reference over one set of doses.
// Throughput: one sample per cycle while a set accumulates.
// After the marked sample the bit-serial divider runs twice, over
//   SQ_W = 32 + clog2(MAX_SAMPLES+1) bits, and the 16-step root unit runs
//   once before a result is valid; input stalls then.
// Reset: reference 0, accumulators cleared, no result pending.
// ----------------------------------------------------------------------------
`include "dose_set_statistics_macros.svh"

module dose_set_statistics #(
  parameter int MAX_SAMPLES = dss_pkg::MAX_SAMPLES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // sample stream
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  dss_pkg::dss_in_t           in_data_i,
  // result stream
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output dss_pkg::dss_out_t          out_data_o,
  // reference dose register
  input  logic                       cfg_we_i,
  input  logic [dss_pkg::DOSE_W-1:0] cfg_wdata_i
);
  import dss_pkg::*;

  // Commands from the sequencer to the datapath. While the controller sits
  // in its accumulate state every offered sample is taken; a marked sample
  // kicks off the mean division, the squared-deviation division and the root.
  // A finished result waits in the datapath's output register, and the next
  // set starts accumulating as soon as that register is loaded.
  dss_cmd_t cmd;

  dss_ctrl #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_i      (in_data_i.last_sample),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // Accumulators saturate at MAX_SAMPLES; samples past that are dropped but
  // a marked one still closes the set.
  dss_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_data_o  (out_data_o)
  );

  // A marked sample must close the input until the result is computed.
  `DSS_ASSERT_NEXT(a_last_stalls, in_valid_i && !in_stall_o && in_data_i.last_sample, in_stall_o, "input open after last sample")
  // Never overwrite a result that is still held.
  `DSS_ASSERT_NOW(a_no_overwrite, cmd.out_load, !out_valid_o || !out_stall_i, "pending result overwritten")
  // Every delivered set has at least one sample, so min cannot exceed max.
  `DSS_ASSERT_NOW(a_min_le_max, out_valid_o, out_data_o.min_dose <= out_data_o.max_dose, "min above max in result")

endmodule

// ===== src/dss_ctrl.sv =====
// ----------------------------------------------------------------------------
// dss_ctrl
// Sequencer: accumulate, then divide twice and take the root, then hand off.
// ----------------------------------------------------------------------------
module dss_ctrl #(
  parameter int MAX_SAMPLES = dss_pkg::MAX_SAMPLES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              last_i,
  output logic              in_stall_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output dss_pkg::dss_cmd_t cmd_o
);
  import dss_pkg::*;

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SQ_W   = 2 * DOSE_W + CNT_W;
  localparam int STEP_W = $clog2(SQ_W);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(SQ_W - 1);
  localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_STEPS - 1);

  dss_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic              slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_ACCUM:    if (in_valid_i && last_i) state_d = S_MEAN_LD;
      S_MEAN_LD:  state_d = S_MEAN_RUN;
      S_MEAN_RUN: if (step_q == DIV_LAST) state_d = S_SQ_LD;
      S_SQ_LD:    state_d = S_SQ_RUN;
      S_SQ_RUN:   if (step_q == DIV_LAST) state_d = S_ROOT_LD;
      S_ROOT_LD:  state_d = S_ROOT_RUN;
      S_ROOT_RUN: if (step_q == ROOT_LAST) state_d = S_DONE;
      S_DONE:     if (slot_free) state_d = S_ACCUM;
      default:    state_d = S_ACCUM;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    step_d     = '0;
    case (state_q)
      S_ACCUM: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      S_MEAN_LD: cmd_o.mean_load = 1'b1;
      S_SQ_LD:   cmd_o.sq_load   = 1'b1;
      S_ROOT_LD: cmd_o.root_load = 1'b1;
      S_MEAN_RUN, S_SQ_RUN: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + STEP_W'(1);
      end
      S_ROOT_RUN: begin
        cmd_o.root_step = 1'b1;
        step_d          = step_q + STEP_W'(1);
      end
      S_DONE:  cmd_o.out_load = slot_free;
      default: cmd_o = '0;
    endcase
  end

  assign out_valid_d = cmd_o.out_load || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ACCUM;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== src/dss_datapath.sv =====
// ----------------------------------------------------------------------------
// dss_datapath
// Accumulators, shared restoring divider, bitwise root unit, output register.
// ----------------------------------------------------------------------------
module dss_datapath #(
  parameter int MAX_SAMPLES = dss_pkg::MAX_SAMPLES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dss_pkg::dss_cmd_t         cmd_i,
  input  dss_pkg::dss_in_t          in_data_i,
  input  logic                      cfg_we_i,
  input  logic [dss_pkg::DOSE_W-1:0] cfg_wdata_i,
  output dss_pkg::dss_out_t         out_data_o
);
  import dss_pkg::*;

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W  = DOSE_W + CNT_W;
  localparam int SQ_W   = 2 * DOSE_W + CNT_W;
  localparam int CNT_XW = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

  logic [DOSE_W-1:0] ref_q;
  logic [DOSE_W-1:0] min_q, max_q;
  logic [SUM_W-1:0]  sum_q;
  logic [SQ_W-1:0]   sqsum_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [RAD_W-1:0]  term_q;
  logic              term_vld_q;

  logic [DOSE_W-1:0] dose, diff;
  logic              take;

  assign dose = in_data_i.dose_sample;
  assign diff = (dose >= ref_q) ? (dose - ref_q) : (ref_q - dose);
  assign take = cmd_i.accept && (cnt_q < CNT_MAX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= '0;
    end else if (cfg_we_i) begin
      ref_q <= cfg_wdata_i;
    end
  end

  // accumulate; the square is registered in term_q before it is added to the squared sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q      <= '1;
      max_q      <= '0;
      sum_q      <= '0;
      sqsum_q    <= '0;
      cnt_q      <= '0;
      term_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      min_q      <= '1;
      max_q      <= '0;
      sum_q      <= '0;
      sqsum_q    <= '0;
      cnt_q      <= '0;
      term_vld_q <= 1'b0;
    end else begin
      term_vld_q <= take;
      if (term_vld_q) begin
        sqsum_q <= sqsum_q + SQ_W'(term_q);
      end
      if (take) begin
        if (dose < min_q) min_q <= dose;
        if (dose > max_q) max_q <= dose;
        sum_q <= sum_q + SUM_W'(dose);
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      term_q <= RAD_W'(diff) * RAD_W'(diff);
    end
  end

  // restoring divider, one quotient bit per step; divisor is the count
  logic [SQ_W-1:0]  dq_q;
  logic [CNT_W-1:0] rem_q;
  logic [CNT_W:0]   trial, trial_sub;
  logic             trial_ge;
  logic [DOSE_W-1:0] mean_q;

  assign trial     = {rem_q, dq_q[SQ_W-1]};
  assign trial_ge  = trial >= {1'b0, cnt_q};
  assign trial_sub = trial - {1'b0, cnt_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mean_load) begin
      dq_q  <= SQ_W'(sum_q);
      rem_q <= '0;
    end else if (cmd_i.sq_load) begin
      dq_q   <= sqsum_q;
      rem_q  <= '0;
      mean_q <= dq_q[DOSE_W-1:0];
    end else if (cmd_i.div_step) begin
      dq_q  <= {dq_q[SQ_W-2:0], trial_ge};
      rem_q <= trial_ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  // floor square root, two radicand bits per step
  logic [RAD_W-1:0] rad_q, root_q, bit_q;
  logic [RAD_W-1:0] tsum;
  logic             root_ge;

  assign tsum    = root_q + bit_q;
  assign root_ge = rad_q >= tsum;

  always_ff @(posedge clk_i) begin
    if (cmd_i.root_load) begin
      rad_q  <= dq_q[RAD_W-1:0];
      root_q <= '0;
      bit_q  <= RAD_W'(1) << (RAD_W - 2);
    end else if (cmd_i.root_step) begin
      if (root_ge) begin
        rad_q  <= rad_q - tsum;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // output register
  logic [CNT_XW-1:0] cnt_x;
  dss_out_t          out_q;

  assign cnt_x = CNT_XW'(cnt_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.min_dose      <= min_q;
      out_q.max_dose      <= max_q;
      out_q.mean_dose     <= mean_q;
      out_q.rms_deviation <= root_q[DOSE_W-1:0];
      out_q.sample_count  <= cnt_x[COUNT_OUT_W-1:0];
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== test/dss_stats_checker.sv =====
// ----------------------------------------------------------------------------
// dss_stats_checker
// Watches the sample, result and reference ports of the dose set statistics
// block, predicts the statistics of every closed set and compares each
// delivered result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module dss_stats_checker #(
  parameter int MAX_SAMPLES = dss_pkg::MAX_SAMPLES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  dss_pkg::dss_in_t           in_data_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  dss_pkg::dss_out_t          out_data_i,
  input  logic                       cfg_we_i,
  input  logic [dss_pkg::DOSE_W-1:0] cfg_wdata_i,
  output logic [31:0]                mismatches_o,
  output logic [31:0]                pending_o
);
  import dss_pkg::*;

  logic [DOSE_W-1:0]      ref_dose;
  logic [DOSE_W-1:0]      lo_dose;
  logic [DOSE_W-1:0]      hi_dose;
  logic [31:0]            dose_sum;
  logic [47:0]            sq_sum;
  logic [COUNT_OUT_W-1:0] n_taken;
  dss_out_t               stats_due[$];
  int unsigned            n_bad = 0;

  assign mismatches_o = n_bad;

  // Largest r with r*r <= v, built one bit at a time from the top.
  function automatic logic [15:0] floor_root(logic [31:0] v);
    logic [15:0] r;
    logic [15:0] t;
    r = '0;
    for (int b = 15; b >= 0; b--) begin
      t = r | (16'd1 << b);
      if (32'(t) * 32'(t) <= v) r = t;
    end
    return r;
  endfunction

  task automatic clear_set();
    lo_dose  = '1;
    hi_dose  = '0;
    dose_sum = '0;
    sq_sum   = '0;
    n_taken  = '0;
  endtask

  task automatic report(string msg);
    n_bad++;
    $display("[%0t] stats mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, longint unsigned got, longint unsigned want);
    if (got != want) report($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic fold_sample(dss_in_t s);
    logic [DOSE_W-1:0] gap;
    dss_out_t          r;
    // Samples past the set limit are dropped; a mark still closes the set.
    if (n_taken < COUNT_OUT_W'(MAX_SAMPLES)) begin
      gap = (s.dose_sample >= ref_dose) ? s.dose_sample - ref_dose
                                        : ref_dose - s.dose_sample;
      if (s.dose_sample < lo_dose) lo_dose = s.dose_sample;
      if (s.dose_sample > hi_dose) hi_dose = s.dose_sample;
      dose_sum += 32'(s.dose_sample);
      sq_sum   += 48'(gap) * 48'(gap);
      n_taken++;
    end
    if (s.last_sample) begin
      r.min_dose      = lo_dose;
      r.max_dose      = hi_dose;
      r.mean_dose     = DOSE_W'(dose_sum / 32'(n_taken));
      r.rms_deviation = floor_root(32'(sq_sum / 48'(n_taken)));
      r.sample_count  = n_taken;
      stats_due.insert(stats_due.size(), r);
      clear_set();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dss_out_t want;
    if (!rst_ni) begin
      ref_dose = '0;
      clear_set();
      stats_due.delete();
      pending_o <= '0;
    end else begin
      // Retire results before folding in a new sample on the same edge.
      if (out_valid_i && !out_stall_i) begin
        if (stats_due.size() == 0) begin
          report($sformatf("result with no set closed: min %0d max %0d count %0d",
                           out_data_i.min_dose, out_data_i.max_dose,
                           out_data_i.sample_count));
        end else begin
          want = stats_due.pop_front();
          check_field("min_dose", out_data_i.min_dose, want.min_dose);
          check_field("max_dose", out_data_i.max_dose, want.max_dose);
          check_field("mean_dose", out_data_i.mean_dose, want.mean_dose);
          check_field("rms_deviation", out_data_i.rms_deviation, want.rms_deviation);
          check_field("sample_count", out_data_i.sample_count, want.sample_count);
        end
      end
      if (in_valid_i && !in_stall_i) fold_sample(in_data_i);
      if (cfg_we_i) ref_dose = cfg_wdata_i;
      pending_o <= stats_due.size();
    end
  end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the dose set statistics block: directed sets at
// the dose extremes and across a reference change, then random sets under
// several reference doses, with random gaps on the sample side and random
// stalls on the result side. Checking lives in dss_stats_checker.
// ----------------------------------------------------------------------------
module tb;
  import dss_pkg::*;

  // Leave margin after the last result before touching the reference or
  // deciding the verdict.
  localparam int SETTLE = 160;
  // Slowest legal run stays far below this.
  localparam int LIMIT  = 2_000_000;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  dss_in_t           in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  dss_out_t          out_data;
  logic              cfg_we    = 1'b0;
  logic [DOSE_W-1:0] cfg_wdata = '0;
  logic [31:0]       mismatches;
  logic [31:0]       pending;

  // Reference as last written, to aim some doses close to it.
  logic [DOSE_W-1:0] ref_now   = '0;
  // Set during stretches that run with no gaps and no stalls.
  bit                quiet     = 1'b0;
  int unsigned       hold_left = 0;
  int unsigned       cycles    = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  dose_set_statistics #(
    .MAX_SAMPLES(MAX_SAMPLES_DEF)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  dss_stats_checker #(
    .MAX_SAMPLES(MAX_SAMPLES_DEF)
  ) stats_chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  // Gap length: from the lower range nine times in ten, else from the upper one.
  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  // Dose mix: full range mostly, the two extremes often, and values close
  // to the reference so that small deviations show up too.
  function automatic logic [DOSE_W-1:0] pick_dose();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return DOSE_W'(ref_now + DOSE_W'($urandom_range(0, 6)) - DOSE_W'(3));
      default: return DOSE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Set length: mostly short sets, some medium, a few long ones.
  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(1, 6);
    if (r < 9) return $urandom_range(7, 40);
    return $urandom_range(41, 120);
  endfunction

  // Result side: hold stall for a random stretch, or release it.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!quiet && $urandom_range(0, 99) < 25) begin
      out_stall <= 1'b1;
      hold_left <= pick_gap() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: a hung block ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Present one item and hold it until the block takes it. Entered and left
  // on a rising edge; valid stays high into the next item unless a gap is
  // drawn, so it is never dropped and raised in the same step.
  task automatic send_sample(logic [DOSE_W-1:0] dose, logic last);
    in_valid <= 1'b1;
    in_data  <= '{dose, last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!quiet && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  // Random set of len samples; close marks the final one.
  task automatic send_set(int unsigned len, bit close);
    for (int unsigned i = 0; i < len; i++) send_sample(pick_dose(), close && (i == len - 1));
  endtask

  // Drain: wait for every predicted result, then give an open set time to
  // finish whatever the block still does with it.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write the reference; only called once the block has settled.
  task automatic set_reference(logic [DOSE_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    ref_now    = v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int unsigned sent;
    int unsigned len;
    logic [DOSE_W-1:0] ref_pick;

    // Hold reset low from the start, then release it on an edge.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-sample sets at both dose extremes, reference still at reset.
    send_sample('0, 1'b1);
    send_sample('1, 1'b1);
    settle();

    // Reference at the top: deviations span the whole range.
    set_reference('1);
    send_sample('0, 1'b0);
    send_sample('1, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h1234, 1'b1);
    settle();

    // Reference at zero and all doses at the top: mean and RMS at maximum.
    set_reference('0);
    repeat (3) send_sample('1, 1'b0);
    send_sample('1, 1'b1);
    settle();

    // Change the reference in the middle of an open set.
    set_reference(16'd12345);
    send_sample(16'h5555, 1'b0);
    send_sample(16'hAAAA, 1'b0);
    send_sample(16'h0001, 1'b0);
    settle();
    set_reference(16'd40000);
    send_sample(16'hFFFE, 1'b0);
    send_sample(16'h0100, 1'b1);
    settle();

    // Random sets under several references; even phases leave a set open
    // so that it straddles the next reference write.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       ref_pick = '0;
        1:       ref_pick = '1;
        default: ref_pick = DOSE_W'($urandom_range(0, 65535));
      endcase
      set_reference(ref_pick);
      quiet = (p == 3);
      sent  = 0;
      while (sent < 165) begin
        len   = pick_len();
        sent += len;
        send_set(len, (p % 2 == 1) || (sent < 165));
      end
      settle();
    end

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
